>>> rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants for the integer matrix multiply block: opcodes,
// command kinds, queue entry layout, engine states and register indexes.
// ----------------------------------------------------------------------------
package imm_pkg;

  // Fixed field widths of the item, result and register ports
  localparam int COORD_W     = 4;
  localparam int VALUE_W     = 16;
  localparam int RESULT_W    = 32;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_COUNT = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Command queue between front and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_WR_A   = 2'd0,
    KIND_WR_B   = 2'd1,
    KIND_RD     = 2'd2,
    KIND_RD_BAD = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    kind_t                      kind;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

>>> rtl/integer_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top
// Signed integer matrix multiply C = A x B, one product element per read.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall, fields op, row, col, value): op 0
//   writes A[row][col], op 1 writes B[row][col], op 2 asks for C[row][col].
//   Op 3 is taken and dropped. Each read gives one result on the result
//   channel (result_valid / result_stall): out_row, out_col, product and
//   out_of_range. Reads outside rows_a x cols_b return zero with the flag set.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets rows_a,
//   inner_size and cols_b; cfg_ready is always high. Write it only when idle.
// Timing:
//   Writes go straight into the store from the idle state. A product read is
//   carried out by the engine's single
//   multiply-accumulate, which walks the inner dimension one term per cycle
//   through the registered store read and product register. Items queue in a
//   two-entry buffer, so the front keeps taking items while the engine works.
// Reset: queue emptied, engine idle, no result pending, all sizes set to 16.
//   Store contents are not cleared. A stalled result holds its value, and
//   the engine waits for the slot before finishing the next read.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_top import imm_pkg::*; #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [1:0]                 op,
  input  logic [COORD_W-1:0]         row,
  input  logic [COORD_W-1:0]         col,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [COORD_W-1:0]         out_row,
  output logic [COORD_W-1:0]         out_col,
  output logic signed [RESULT_W-1:0] product,
  output logic                       out_of_range,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_size;
  logic [CFG_W-1:0] cols_b;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  // Size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= CFG_RESET;
      inner_size <= CFG_RESET;
      cols_b     <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS_A:     rows_a     <= cfg_data;
        CFG_INNER_SIZE: inner_size <= cfg_data;
        CFG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  imm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .row        (row),
    .col        (col),
    .value      (value),
    .rows_a     (rows_a),
    .cols_b     (cols_b),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  imm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  imm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .inner_size   (inner_size),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .product      (product),
    .out_of_range (out_of_range)
  );

endmodule

>>> rtl/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/imm_front.sv
// ----------------------------------------------------------------------------
// imm_front
// Item front end: accepts items, drops unused opcodes, checks product reads
// against the configured size and pushes one command per useful item.
// ----------------------------------------------------------------------------
module imm_front import imm_pkg::*; #(
  parameter int MAX_DIM = 16
) (
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                op,
  input  logic [COORD_W-1:0]        row,
  input  logic [COORD_W-1:0]        col,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [CFG_W-1:0]          rows_a,
  input  logic [CFG_W-1:0]          cols_b,
  input  logic                      q_full,
  output logic                      push,
  output cmd_t                      push_cmd
);

  localparam int CW = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;

  logic [CW-1:0] rows_ext;
  logic [CW-1:0] cols_ext;
  logic [CW-1:0] rows_lim;
  logic [CW-1:0] cols_lim;
  logic          bad;
  logic          useful;

  // Clamp the size registers to 1..MAX_DIM
  always_comb begin
    rows_ext = CW'(rows_a);
    cols_ext = CW'(cols_b);
    if (rows_ext == '0) begin
      rows_lim = CW'(1);
    end else if (rows_ext > CW'(MAX_DIM)) begin
      rows_lim = CW'(MAX_DIM);
    end else begin
      rows_lim = rows_ext;
    end
    if (cols_ext == '0) begin
      cols_lim = CW'(1);
    end else if (cols_ext > CW'(MAX_DIM)) begin
      cols_lim = CW'(MAX_DIM);
    end else begin
      cols_lim = cols_ext;
    end
  end

  assign bad = (CW'(row) >= rows_lim) || (CW'(col) >= cols_lim);

  // Classify the item
  always_comb begin
    useful        = 1'b1;
    push_cmd.kind = KIND_WR_A;
    unique case (op)
      OP_WRITE_A: push_cmd.kind = KIND_WR_A;
      OP_WRITE_B: push_cmd.kind = KIND_WR_B;
      OP_READ:    push_cmd.kind = bad ? KIND_RD_BAD : KIND_RD;
      default:    useful = 1'b0;
    endcase
    push_cmd.row   = row;
    push_cmd.col   = col;
    push_cmd.value = value;
  end

  // Hold items while the queue is full; unused opcodes are taken and dropped
  assign item_stall = q_full;
  assign push       = item_valid && !q_full && useful;

endmodule

>>> rtl/imm_fifo.sv
// ----------------------------------------------------------------------------
// imm_fifo
// Short command queue between the front end and the multiply engine.
// ----------------------------------------------------------------------------
module imm_fifo import imm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr;
  logic [QUEUE_PTR_W-1:0] rptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QUEUE_CNT_W'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QUEUE_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/imm_back.sv
// ----------------------------------------------------------------------------
// imm_back
// Multiply engine: carries out store writes, and walks the inner dimension
// one multiply-accumulate per cycle for each product read.
// ----------------------------------------------------------------------------
module imm_back import imm_pkg::*; #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       head,
  input  logic                       q_empty,
  output logic                       pop,
  input  logic [CFG_W-1:0]           inner_size,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [COORD_W-1:0]         out_row,
  output logic [COORD_W-1:0]         out_col,
  output logic signed [RESULT_W-1:0] product,
  output logic                       out_of_range
);

  localparam int CW     = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0]  wrap_tbl [COORD_COUNT];
  logic [CW-1:0]     inner_ext;
  logic [CW-1:0]     inner_lim;
  logic [CW-1:0]     k;
  logic [IDX_W-1:0]  k_idx;
  logic              k_last;
  logic [IDX_W-1:0]  cur_row;
  logic [IDX_W-1:0]  cur_col;
  logic [COORD_W-1:0] echo_row;
  logic [COORD_W-1:0] echo_col;

  logic              start;
  logic              issue;
  logic              we_a;
  logic              we_b;
  logic              load_bad;
  logic              load_good;
  logic              slot_free;

  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr_a;
  logic [ADDR_W-1:0]     raddr_b;
  logic [ELEM_WIDTH-1:0] wdata;
  logic [ELEM_WIDTH-1:0] rdata_a;
  logic [ELEM_WIDTH-1:0] rdata_b;

  logic                          rd_vld;
  logic                          rd_last;
  logic                          mul_vld;
  logic                          mul_last;
  logic signed [2*ELEM_WIDTH-1:0] prod_full;
  logic signed [RESULT_W-1:0]    mul;
  logic signed [RESULT_W-1:0]    acc;

  // Coordinate wrap table: index modulo MAX_DIM
  always_comb begin
    for (int i = 0; i < COORD_COUNT; i++) begin
      wrap_tbl[i] = IDX_W'(i % MAX_DIM);
    end
  end

  // Clamp the inner size to 1..MAX_DIM
  always_comb begin
    inner_ext = CW'(inner_size);
    if (inner_ext == '0) begin
      inner_lim = CW'(1);
    end else if (inner_ext > CW'(MAX_DIM)) begin
      inner_lim = CW'(MAX_DIM);
    end else begin
      inner_lim = inner_ext;
    end
  end

  assign k_idx     = k[IDX_W-1:0];
  assign k_last    = (k == inner_lim - CW'(1));
  assign slot_free = !result_valid || !result_stall;

  // Store addresses: row-major, MAX_DIM entries per row
  assign waddr   = ADDR_W'(wrap_tbl[head.row]) * ADDR_W'(MAX_DIM)
                 + ADDR_W'(wrap_tbl[head.col]);
  assign raddr_a = ADDR_W'(cur_row) * ADDR_W'(MAX_DIM) + ADDR_W'(k_idx);
  assign raddr_b = ADDR_W'(k_idx) * ADDR_W'(MAX_DIM) + ADDR_W'(cur_col);
  assign wdata   = ELEM_WIDTH'(head.value);

  imm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  imm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    load_bad   = 1'b0;
    load_good  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            KIND_WR_A: begin
              pop  = 1'b1;
              we_a = 1'b1;
            end
            KIND_WR_B: begin
              pop  = 1'b1;
              we_b = 1'b1;
            end
            KIND_RD: begin
              pop        = 1'b1;
              start      = 1'b1;
              state_next = ST_RUN;
            end
            KIND_RD_BAD: begin
              if (slot_free) begin
                pop      = 1'b1;
                load_bad = 1'b1;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mul_vld && mul_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          load_good  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Latch the read position and step the inner index
  always_ff @(posedge clk) begin
    if (start) begin
      k        <= '0;
      cur_row  <= wrap_tbl[head.row];
      cur_col  <= wrap_tbl[head.col];
      echo_row <= head.row;
      echo_col <= head.col;
    end else if (issue) begin
      k <= k + CW'(1);
    end
  end

  // Pipeline flags for read data and products
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_last  <= 1'b0;
      mul_vld  <= 1'b0;
      mul_last <= 1'b0;
    end else begin
      rd_vld   <= issue;
      rd_last  <= issue && k_last;
      mul_vld  <= rd_vld;
      mul_last <= rd_vld && rd_last;
    end
  end

  // Multiply, register, then accumulate with 32-bit wrap
  assign prod_full = $signed(rdata_a) * $signed(rdata_b);

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      mul <= RESULT_W'(prod_full);
    end
    if (start) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + mul;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_bad || load_good) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_bad) begin
      out_row      <= head.row;
      out_col      <= head.col;
      product      <= '0;
      out_of_range <= 1'b1;
    end else if (load_good) begin
      out_row      <= echo_row;
      out_col      <= echo_col;
      product      <= acc;
      out_of_range <= 1'b0;
    end
  end

endmodule

>>> rtl/imm_chk.sv
// ----------------------------------------------------------------------------
// imm_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module imm_chk import imm_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [COORD_W-1:0]         out_row,
  input logic [COORD_W-1:0]         out_col,
  input logic signed [RESULT_W-1:0] product,
  input logic                       out_of_range
);

  // Out-of-range reads carry a zero product
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_of_range |-> product == '0)
    else $error("out-of-range result with non-zero product");

  // No result straight after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // A stalled result stays offered
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  // A stalled result keeps its payload
  a_stall_holds_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      $stable(out_row) && $stable(out_col) && $stable(product) && $stable(out_of_range))
    else $error("stalled result changed");

endmodule

bind integer_matrix_multiply_top imm_chk u_chk (.*);
